// ===== design/ufe_pkg.sv =====
// Shared types, constants and helpers for the URL form encoder.
package ufe_pkg;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [6:0]  CharPct   = 7'h25;
  localparam logic [6:0]  CharPlus  = 7'h2B;
  localparam logic [15:0] CodeSpace = 16'h0020;
  localparam logic [15:0] MaxOneByte = 16'h007F;
  localparam logic [15:0] MaxTwoByte = 16'h07FF;
  localparam logic [7:0]  LeadTwo   = 8'hC0;
  localparam logic [7:0]  LeadThree = 8'hE0;
  localparam logic [7:0]  ContByte  = 8'h80;

  typedef enum logic {
    KIND_LITERAL,
    KIND_ESCAPE
  } kind_e;

  typedef enum logic [1:0] {
    POS_PCT,
    POS_HI,
    POS_LO
  } pos_e;

  // One classified character. A literal keeps its output character in byte0.
  typedef struct packed {
    kind_e      kind;
    logic [1:0] last_idx;
    logic [7:0] byte2;
    logic [7:0] byte1;
    logic [7:0] byte0;
  } entry_t;

  function automatic logic [6:0] hex_digit(input logic [3:0] nib);
    logic [6:0] res;
    if (nib < 4'd10) begin
      res = 7'h30 + {3'b000, nib};
    end else begin
      res = 7'h57 + {3'b000, nib};
    end
    return res;
  endfunction

endpackage

// ===== design/url_form_encoder.sv =====
// Top level of the URL form encoder: front classifier, queue and character sequencer.
//
// The slave channel takes one 16-bit character code per request. The master
// channel returns its URL form-encoded text as 7-bit ASCII characters, one per
// request, with tlast on the final character for that code. Letters, digits
// and the unreserved marks give one character, space gives '+', other codes
// give one, two or three "%xx" triplets of their UTF-8 bytes (3, 6 or 9
// characters, lowercase hex).
// A taken code is first written into the queue; the back end then loads its
// first character into the output register. While the master side is ready,
// the back end emits one character per cycle and single-character codes stream
// at one per cycle. A two-entry queue lets the front accept codes while the
// back drains an escape; tready drops only when that queue is full.
// A stall on the master side holds the output register; the queue then fills
// and back-pressures the slave side. Reset empties the queue and the output
// register and restarts the character sequencer.
module url_form_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] char_code
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [6:0] out_char, [7] zero
  output logic        m_axis_tlast_o
);

  ufe_pkg::entry_t front_entry;
  ufe_pkg::entry_t head_entry;
  logic            q_full;
  logic            head_valid;
  logic            pop;
  logic [6:0]      out_char;

  ufe_front u_front (
    .char_code_i (s_axis_tdata_i),
    .entry_o     (front_entry)
  );

  ufe_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (s_axis_tvalid_i),
    .push_entry_i (front_entry),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_entry_o (head_entry)
  );

  ufe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_entry_i (head_entry),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_char_o   (out_char),
    .out_last_o   (m_axis_tlast_o)
  );

  assign s_axis_tready_o = !q_full;
  assign m_axis_tdata_o  = {1'b0, out_char};

endmodule

// ===== design/ufe_front.sv =====
// Front end: classifies one character code into a literal or a run of UTF-8 bytes.
module ufe_front (
  input  logic [15:0]     char_code_i,
  output ufe_pkg::entry_t entry_o
);

  logic pass;

  always_comb begin
    pass = (char_code_i inside {[16'h0041:16'h005A], [16'h0061:16'h007A],
                                [16'h0030:16'h0039]}) ||
           (char_code_i inside {16'h002D, 16'h005F, 16'h002E, 16'h0021, 16'h007E,
                                16'h002A, 16'h0027, 16'h0028, 16'h0029});
  end

  always_comb begin
    entry_o = '0;
    if (pass) begin
      entry_o.kind  = ufe_pkg::KIND_LITERAL;
      entry_o.byte0 = {1'b0, char_code_i[6:0]};
    end else if (char_code_i == ufe_pkg::CodeSpace) begin
      entry_o.kind  = ufe_pkg::KIND_LITERAL;
      entry_o.byte0 = {1'b0, ufe_pkg::CharPlus};
    end else if (char_code_i <= ufe_pkg::MaxOneByte) begin
      entry_o.kind     = ufe_pkg::KIND_ESCAPE;
      entry_o.last_idx = 2'd0;
      entry_o.byte0    = char_code_i[7:0];
    end else if (char_code_i <= ufe_pkg::MaxTwoByte) begin
      entry_o.kind     = ufe_pkg::KIND_ESCAPE;
      entry_o.last_idx = 2'd1;
      entry_o.byte0    = ufe_pkg::LeadTwo | {3'b000, char_code_i[10:6]};
      entry_o.byte1    = ufe_pkg::ContByte | {2'b00, char_code_i[5:0]};
    end else begin
      entry_o.kind     = ufe_pkg::KIND_ESCAPE;
      entry_o.last_idx = 2'd2;
      entry_o.byte0    = ufe_pkg::LeadThree | {4'h0, char_code_i[15:12]};
      entry_o.byte1    = ufe_pkg::ContByte | {2'b00, char_code_i[11:6]};
      entry_o.byte2    = ufe_pkg::ContByte | {2'b00, char_code_i[5:0]};
    end
  end

endmodule

// ===== design/ufe_queue.sv =====
// Short queue of classified characters between the front and back ends.
module ufe_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ufe_pkg::entry_t push_entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            head_valid_o,
  output ufe_pkg::entry_t head_entry_o
);

  ufe_pkg::entry_t                 mem_q [ufe_pkg::QDepth];
  logic [ufe_pkg::QPtrW-1:0]       wr_ptr_q, wr_ptr_d;
  logic [ufe_pkg::QPtrW-1:0]       rd_ptr_q, rd_ptr_d;
  logic [ufe_pkg::QCntW-1:0]       count_q, count_d;
  logic                            do_push, do_pop;

  localparam logic [ufe_pkg::QCntW-1:0] Depth = ufe_pkg::QCntW'(ufe_pkg::QDepth);
  localparam logic [ufe_pkg::QPtrW-1:0] LastPtr = ufe_pkg::QPtrW'(ufe_pkg::QDepth - 1);

  assign full_o       = (count_q == Depth);
  assign head_valid_o = (count_q != '0);
  assign head_entry_o = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Depth)
    else $error("queue count exceeds depth");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == Depth) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");
`endif

endmodule

// ===== design/ufe_back.sv =====
// Back end: walks one queued entry and emits its characters into an output register.
module ufe_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  ufe_pkg::entry_t head_entry_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [6:0]      out_char_o,
  output logic            out_last_o
);

  ufe_pkg::pos_e pos_q, pos_d;
  logic [1:0]    byte_q, byte_d;
  logic          out_valid_q, out_valid_d;
  logic [6:0]    out_char_q, out_char_d;
  logic          out_last_q, out_last_d;
  logic          adv;
  logic          is_last;
  logic [7:0]    cur_byte;
  logic [6:0]    cur_char;

  assign adv = head_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    case (byte_q)
      2'd0:    cur_byte = head_entry_i.byte0;
      2'd1:    cur_byte = head_entry_i.byte1;
      default: cur_byte = head_entry_i.byte2;
    endcase
  end

  always_comb begin
    if (head_entry_i.kind == ufe_pkg::KIND_LITERAL) begin
      cur_char = head_entry_i.byte0[6:0];
      is_last  = 1'b1;
    end else begin
      case (pos_q)
        ufe_pkg::POS_PCT: cur_char = ufe_pkg::CharPct;
        ufe_pkg::POS_HI:  cur_char = ufe_pkg::hex_digit(cur_byte[7:4]);
        default:          cur_char = ufe_pkg::hex_digit(cur_byte[3:0]);
      endcase
      is_last = (pos_q == ufe_pkg::POS_LO) && (byte_q == head_entry_i.last_idx);
    end
  end

  always_comb begin
    pos_d       = pos_q;
    byte_d      = byte_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (adv) begin
      out_valid_d = 1'b1;
      out_char_d  = cur_char;
      out_last_d  = is_last;
      if (is_last) begin
        pos_d  = ufe_pkg::POS_PCT;
        byte_d = 2'd0;
      end else if (pos_q == ufe_pkg::POS_LO) begin
        pos_d  = ufe_pkg::POS_PCT;
        byte_d = byte_q + 2'd1;
      end else if (pos_q == ufe_pkg::POS_PCT) begin
        pos_d = ufe_pkg::POS_HI;
      end else begin
        pos_d = ufe_pkg::POS_LO;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= ufe_pkg::POS_PCT;
      byte_q      <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      byte_q      <= byte_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign pop_o       = adv && is_last;
  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

`ifndef SYNTHESIS
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (pos_q == ufe_pkg::POS_PCT) && (byte_q == 2'd0))
    else $error("sequencer did not restart after the final character");

  a_byte_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_valid_i && head_entry_i.kind == ufe_pkg::KIND_ESCAPE)
      |-> (byte_q <= head_entry_i.last_idx))
    else $error("byte index ran past the last byte of the entry");
`endif

endmodule

// ===== dv/ufe_checker.sv =====
// Checker for the URL form encoder: predicts the encoded characters and compares them.
`timescale 1ns / 100ps

module ufe_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [15:0] s_axis_tdata_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [7:0]  m_axis_tdata_i,
  input  logic        m_axis_tlast_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } enc_char_t;

  enc_char_t   expected_chars[$];
  int unsigned mismatches;

  initial begin
    mismatches   = 0;
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic logic [6:0] nibble_ascii(input logic [3:0] nib);
    logic [6:0] ch;
    if (nib < 4'd10) begin
      ch = 7'h30 + 7'(nib);
    end else begin
      ch = 7'h61 + 7'(nib - 4'd10);
    end
    return ch;
  endfunction

  // Letters, digits and the unreserved marks go out unchanged.
  function automatic bit is_unreserved(input logic [15:0] code);
    bit ok;
    ok = 1'b0;
    if ((code >= "A" && code <= "Z") || (code >= "a" && code <= "z") ||
        (code >= "0" && code <= "9")) begin
      ok = 1'b1;
    end
    case (code)
      "-", "_", ".", "!", "~", "*", "'", "(", ")": ok = 1'b1;
      default: ;
    endcase
    return ok;
  endfunction

  task automatic push_char(input logic [6:0] ch);
    enc_char_t c;
    c.ch   = ch;
    c.last = 1'b0;
    expected_chars.push_back(c);
  endtask

  task automatic push_escape(input logic [7:0] b);
    push_char(ufe_pkg::CharPct);
    push_char(nibble_ascii(b[7:4]));
    push_char(nibble_ascii(b[3:0]));
  endtask

  task automatic predict_encoding(input logic [15:0] code);
    enc_char_t tail;
    if (is_unreserved(code)) begin
      push_char(code[6:0]);
    end else if (code == ufe_pkg::CodeSpace) begin
      push_char(ufe_pkg::CharPlus);
    end else if (code <= ufe_pkg::MaxOneByte) begin
      push_escape(code[7:0]);
    end else if (code <= ufe_pkg::MaxTwoByte) begin
      push_escape(ufe_pkg::LeadTwo | {3'b000, code[10:6]});
      push_escape(ufe_pkg::ContByte | {2'b00, code[5:0]});
    end else begin
      // Surrogates are not paired; they take the plain three-byte form.
      push_escape(ufe_pkg::LeadThree | {4'b0000, code[15:12]});
      push_escape(ufe_pkg::ContByte | {2'b00, code[11:6]});
      push_escape(ufe_pkg::ContByte | {2'b00, code[5:0]});
    end
    tail      = expected_chars.pop_back();
    tail.last = 1'b1;
    expected_chars.push_back(tail);
  endtask

  always @(posedge clk_i) begin
    enc_char_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_chars.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected character: expected none, actual %h last %b",
                   $time, m_axis_tdata_i, m_axis_tlast_i);
        end else begin
          want = expected_chars.pop_front();
          if (m_axis_tdata_i !== {1'b0, want.ch}) begin
            mismatches++;
            $display("%0t: out_char mismatch: expected %h, actual %h",
                     $time, {1'b0, want.ch}, m_axis_tdata_i);
          end
          if (m_axis_tlast_i !== want.last) begin
            mismatches++;
            $display("%0t: last mismatch: expected %b, actual %b",
                     $time, want.last, m_axis_tlast_i);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        predict_encoding(s_axis_tdata_i);
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_chars.size();
  end

endmodule

// ===== dv/tb_url_form_encoder.sv =====
// Testbench top for the URL form encoder: stimulus, output stalls, watchdog and verdict.
`timescale 1ns / 100ps

module tb_url_form_encoder;

  localparam int unsigned WatchLimit = 1000;
  localparam int unsigned DrainCycles = 30;

  typedef enum int unsigned {
    RX_ALWAYS,
    RX_RANDOM,
    RX_BURSTY
  } rx_mode_e;

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        m_tlast;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned idle_cycles;
  int unsigned burst_left;
  int unsigned gap_max;
  int unsigned stall_left;
  rx_mode_e    rx_mode;

  url_form_encoder u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  ufe_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tlast_i  (m_tlast),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver back-pressure; the pattern depends on the current mode.
  always @(posedge clk_i) begin
    case (rx_mode)
      RX_ALWAYS: m_tready <= 1'b1;
      RX_RANDOM: m_tready <= ($urandom_range(0, 9) < 7);
      default: begin
        if (stall_left != 0) begin
          stall_left <= stall_left - 1;
          m_tready   <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
          stall_left <= $urandom_range(0, 11);
          m_tready   <= 1'b0;
        end else begin
          m_tready <= 1'b1;
        end
      end
    endcase
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    do @(posedge clk_i); while (idle_cycles < WatchLimit);
    $display("%0t: no request accepted for %0d cycles", $time, WatchLimit);
    $display("simulation failed");
    $finish;
  end

  // Hold one code on the slave channel until it is taken, then maybe pause.
  task automatic send_code(input logic [15:0] code);
    int unsigned gap;
    s_tdata  <= code;
    s_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_tready);
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  function automatic logic [15:0] pick_code();
    int unsigned sel;
    logic [15:0] code;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      code = 16'($urandom_range(0, 16'h007F));
    end else if (sel < 6) begin
      code = 16'($urandom_range(16'h0080, 16'h07FF));
    end else if (sel < 9) begin
      code = 16'($urandom_range(16'h0800, 16'hFFFF));
    end else begin
      code = 16'($urandom());
    end
    return code;
  endfunction

  initial begin
    logic [15:0] directed_codes[$];
    rx_mode_e    phase_rx[5];
    int unsigned phase_gap[5];

    rst_ni      = 1'b0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    m_tready    = 1'b0;
    idle_cycles = 0;
    stall_left  = 0;
    burst_left  = 0;
    gap_max     = 2;
    rx_mode     = RX_RANDOM;

    directed_codes = '{16'h0000, "A", "Z", "a", "z", "0", "9",
                       "-", "_", ".", "!", "~", "*", "'", "(", ")",
                       16'h0020, 16'h0025, 16'h007F, 16'h0080, 16'h07FF,
                       16'h0800, 16'hD800, 16'hDFFF, 16'hFFFF};
    phase_rx  = '{RX_ALWAYS, RX_RANDOM, RX_BURSTY, RX_BURSTY, RX_RANDOM};
    phase_gap = '{0, 3, 4, 0, 2};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_codes[i]) begin
      send_code(directed_codes[i]);
    end

    for (int p = 0; p < 5; p++) begin
      rx_mode <= phase_rx[p];
      gap_max = phase_gap[p];
      for (int n = 0; n < 60; n++) begin
        send_code(pick_code());
      end
    end
    s_tvalid <= 1'b0;

    // Let the checker count the last accepted code before watching the drain.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/ufe_pkg.sv
design/ufe_front.sv
design/ufe_queue.sv
design/ufe_back.sv
design/url_form_encoder.sv
dv/ufe_checker.sv
dv/tb_url_form_encoder.sv
